[sv/sfdl_pkg.sv]
`timescale 1ns / 1ps

package sfdl_pkg;

    localparam int PIXEL_BITS_DEF = 32;
    localparam int MAX_DIM_DEF    = 4096;

    localparam int PIX_W        = 32;   // pixel field width on the ports
    localparam int CFG_W        = 13;   // widest configuration register
    localparam int SIZE_W       = 13;   // frame_width / frame_height
    localparam int PHASE_W      = 6;    // phase_shift, phases and strides
    localparam int SLIP_W       = 3;
    localparam int LINE_FIELD_W = 12;   // line and column result fields
    localparam int CFG_IDX_W    = 2;

    localparam int RESET_WIDTH  = 1920;
    localparam int RESET_HEIGHT = 1080;
    localparam int RESET_PHASE  = 0;

    // Height thresholds for the slip selection
    localparam int SLIP3_HEIGHT = 540;
    localparam int SLIP4_HEIGHT = 720;
    localparam int SLIP5_HEIGHT = 1080;
    localparam int SLIP6_HEIGHT = 1440;

    // Largest quotient when a 6-bit value is reduced by the smallest stride (3)
    localparam int MOD_STEPS = 21;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_PHASE_SHIFT  = 2'd2
    } t_cfg_idx;

    function automatic logic [SLIP_W-1:0] slip_of(input logic [SIZE_W:0] h);
        logic [SLIP_W-1:0] s;
        if (h < (SIZE_W+1)'(SLIP3_HEIGHT)) begin
            s = 3'd2;
        end else if (h < (SIZE_W+1)'(SLIP4_HEIGHT)) begin
            s = 3'd3;
        end else if (h < (SIZE_W+1)'(SLIP5_HEIGHT)) begin
            s = 3'd4;
        end else if (h < (SIZE_W+1)'(SLIP6_HEIGHT)) begin
            s = 3'd5;
        end else begin
            s = 3'd6;
        end
        return s;
    endfunction

    // slip*slip - 1
    function automatic logic [PHASE_W-1:0] stride_of(input logic [SLIP_W-1:0] s);
        logic [PHASE_W-1:0] st;
        case (s)
            3'd2:    st = 6'd3;
            3'd3:    st = 6'd8;
            3'd4:    st = 6'd15;
            3'd5:    st = 6'd24;
            3'd6:    st = 6'd35;
            default: st = 6'd3;
        endcase
        return st;
    endfunction

    // v mod st for a 6-bit v and a stride of 3 or more: independent compares
    // against constant multiples, the largest one that fits wins.
    function automatic logic [PHASE_W-1:0] mod_stride(input logic [PHASE_W-1:0] v,
                                                      input logic [PHASE_W-1:0] st);
        logic [PHASE_W-1:0] r;
        logic [10:0]        m;
        r = v;
        for (int k = 1; k <= MOD_STEPS; k++) begin
            m = 11'(k) * 11'(st);
            if (11'(v) >= m) begin
                r = v - m[PHASE_W-1:0];
            end
        end
        return r;
    endfunction

endpackage

[sv/sfdl_pix_if.sv]
`timescale 1ns / 1ps

interface sfdl_pix_if;
    logic                        valid;
    logic                        ready;
    logic [sfdl_pkg::PIX_W-1:0]  old_pixel;
    logic [sfdl_pkg::PIX_W-1:0]  new_pixel;

    modport source (output valid, output old_pixel, output new_pixel, input ready);
    modport sink   (input valid, input old_pixel, input new_pixel, output ready);
endinterface

[sv/sfdl_res_if.sv]
`timescale 1ns / 1ps

interface sfdl_res_if;
    logic                               valid;
    logic                               ready;
    logic                               changed;
    logic [sfdl_pkg::LINE_FIELD_W-1:0]  first_dirty_line;
    logic [sfdl_pkg::LINE_FIELD_W-1:0]  last_dirty_line;
    logic [sfdl_pkg::LINE_FIELD_W-1:0]  last_column;

    modport source (output valid, output changed, output first_dirty_line,
                    output last_dirty_line, output last_column, input ready);
    modport sink   (input valid, input changed, input first_dirty_line,
                    input last_dirty_line, input last_column, output ready);
endinterface

[sv/sampled_frame_dirty_line_detector_core.sv]
`timescale 1ns / 1ps

// Channel  | Dir | Payload                                           | Beat
// ---------+-----+---------------------------------------------------+---------------------
// i_pix    | in  | old_pixel[31:0], new_pixel[31:0]                  | one pixel pair
// o_res    | out | changed, first/last_dirty_line[11:0], last_column | one per frame
// i_cfg_*  | in  | idx[1:0], data[12:0] (width, height, phase_shift) | write when i_cfg_we
//
// One beat per clock sustained while the result side keeps up. A beat is held in the
// input register, then the counter / phase update runs in a single pass into the state
// and result registers; a frame result is registered as its last beat leaves the input register.
// Synchronous active-low reset restores register defaults and a clean frame.
// The input register keeps taking beats while a result waits; it only holds
// when a frame-ending beat meets a result that has not yet been taken.

module sampled_frame_dirty_line_detector_core #(
    parameter int PIXEL_BITS = sfdl_pkg::PIXEL_BITS_DEF,
    parameter int MAX_DIM    = sfdl_pkg::MAX_DIM_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sfdl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sfdl_pkg::CFG_W-1:0]     i_cfg_data,
    sfdl_pix_if.sink                       i_pix,
    sfdl_res_if.source                     o_res
);

    localparam int CNT_W  = $clog2(MAX_DIM);          // column / line counters
    localparam int DIM_W  = $clog2(MAX_DIM + 1);      // clamped sizes
    localparam int LINE_W = CNT_W + 1;                // low/high line incl. slip overshoot
    localparam int CMP_W  = sfdl_pkg::SIZE_W + 1;     // wide enough for any MAX_DIM in range
    localparam int PH_W   = sfdl_pkg::PHASE_W;
    localparam int LF_W   = sfdl_pkg::LINE_FIELD_W;

    // ---- configuration registers ----
    logic [sfdl_pkg::SIZE_W-1:0] r_frame_width;
    logic [sfdl_pkg::SIZE_W-1:0] r_frame_height;
    logic [PH_W-1:0]             r_phase_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= sfdl_pkg::SIZE_W'(sfdl_pkg::RESET_WIDTH);
            r_frame_height <= sfdl_pkg::SIZE_W'(sfdl_pkg::RESET_HEIGHT);
            r_phase_shift  <= PH_W'(sfdl_pkg::RESET_PHASE);
        end else if (i_cfg_we) begin
            case (sfdl_pkg::t_cfg_idx'(i_cfg_idx))
                sfdl_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                sfdl_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                sfdl_pkg::CFG_PHASE_SHIFT:  r_phase_shift  <= i_cfg_data[PH_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp sizes to 1..MAX_DIM
    logic [CMP_W-1:0] w_cmp, h_cmp;
    logic [DIM_W-1:0] w_eff, h_eff;

    always_comb begin
        w_cmp = CMP_W'(r_frame_width);
        h_cmp = CMP_W'(r_frame_height);
        if (w_cmp == '0)                 w_cmp = CMP_W'(1);
        else if (w_cmp > CMP_W'(MAX_DIM)) w_cmp = CMP_W'(MAX_DIM);
        if (h_cmp == '0)                 h_cmp = CMP_W'(1);
        else if (h_cmp > CMP_W'(MAX_DIM)) h_cmp = CMP_W'(MAX_DIM);
        w_eff = w_cmp[DIM_W-1:0];
        h_eff = h_cmp[DIM_W-1:0];
    end

    logic [sfdl_pkg::SLIP_W-1:0] slip;
    logic [PH_W-1:0]             stride;
    assign slip   = sfdl_pkg::slip_of(h_cmp);
    assign stride = sfdl_pkg::stride_of(slip);

    // ---- input register ----
    logic                        r_in_valid;
    logic [sfdl_pkg::PIX_W-1:0]  r_old, r_new;
    logic                        out_free, adv;
    logic                        diff, line_end, frame_end;

    // Only a frame-ending beat needs the result register
    assign out_free    = !o_res.valid || o_res.ready;
    assign adv         = r_in_valid && (out_free || !frame_end);
    assign i_pix.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_in_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pix.valid && i_pix.ready) begin
            r_old <= i_pix.old_pixel;
            r_new <= i_pix.new_pixel;
        end
    end

    // ---- frame state ----
    logic [CNT_W-1:0]  r_col, n_col;
    logic [CNT_W-1:0]  r_line, n_line;
    logic [PH_W-1:0]   r_sp, n_sp;
    logic [PH_W-1:0]   r_ls, n_ls;
    logic              r_hit, n_hit;
    logic              r_any, n_any;
    logic [LINE_W-1:0] r_low, n_low;
    logic [LINE_W-1:0] r_high, n_high;

    logic [PH_W-1:0]   ls_reload;
    logic [LINE_W-1:0] y_w, slip_w, h_last, lo_cl, hi_cl;
    logic              res_changed;
    logic [LF_W-1:0]   res_first, res_last, res_col;

    assign diff = (r_old[PIXEL_BITS-1:0] != r_new[PIXEL_BITS-1:0]);
    assign ls_reload = sfdl_pkg::mod_stride(r_phase_shift, stride);
    assign line_end  = (DIM_W'(r_col) + DIM_W'(1)) >= w_eff;
    assign frame_end = line_end && ((DIM_W'(r_line) + DIM_W'(1)) >= h_eff);

    always_comb begin
        y_w    = LINE_W'(r_line);
        slip_w = LINE_W'(slip);
        h_last = LINE_W'(h_eff - DIM_W'(1));

        n_ls  = r_ls;
        n_sp  = r_sp;
        n_hit = r_hit;
        n_any = r_any;
        n_low = r_low;
        n_high = r_high;

        // New line: reload the start phase on the first line, else step it by slip
        if (r_col == '0) begin
            if (r_line == '0) begin
                n_ls = ls_reload;
            end else begin
                n_ls = sfdl_pkg::mod_stride(r_ls + PH_W'(slip), stride);
            end
            n_sp  = n_ls;
            n_hit = 1'b0;
        end

        if (!n_hit) begin
            if (n_sp == '0) begin
                if (diff) begin
                    if (!n_any) begin
                        n_low = (y_w >= slip_w) ? (y_w - slip_w) : '0;
                    end
                    n_any  = 1'b1;
                    n_high = y_w + slip_w;
                    n_hit  = 1'b1;
                end
                n_sp = stride - PH_W'(1);
            end else begin
                n_sp = n_sp - PH_W'(1);
            end
        end

        lo_cl = (n_low  < h_last) ? n_low  : h_last;
        hi_cl = (n_high < h_last) ? n_high : h_last;
        res_changed = n_any;
        res_first   = n_any ? LF_W'(lo_cl) : '0;
        res_last    = n_any ? LF_W'(hi_cl) : '0;
        res_col     = LF_W'(w_eff - DIM_W'(1));

        n_col  = r_col + CNT_W'(1);
        n_line = r_line;
        if (line_end) begin
            n_col  = '0;
            n_line = r_line + CNT_W'(1);
        end
        if (frame_end) begin
            n_line = '0;
            n_ls   = ls_reload;
            n_sp   = ls_reload;
            n_hit  = 1'b0;
            n_any  = 1'b0;
            n_low  = '0;
            n_high = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_line <= '0;
            r_ls   <= ls_reload;
            r_sp   <= ls_reload;
            r_hit  <= 1'b0;
            r_any  <= 1'b0;
            r_low  <= '0;
            r_high <= '0;
        end else if (adv) begin
            r_col  <= n_col;
            r_line <= n_line;
            r_ls   <= n_ls;
            r_sp   <= n_sp;
            r_hit  <= n_hit;
            r_any  <= n_any;
            r_low  <= n_low;
            r_high <= n_high;
        end
    end

    // ---- result register ----
    logic r_out_valid;
    logic r_changed;
    logic [LF_W-1:0] r_first, r_last, r_lcol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && frame_end) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && frame_end) begin
            r_changed <= res_changed;
            r_first   <= res_first;
            r_last    <= res_last;
            r_lcol    <= res_col;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.changed          = r_changed;
    assign o_res.first_dirty_line = r_first;
    assign o_res.last_dirty_line  = r_last;
    assign o_res.last_column      = r_lcol;

    // ---- checks ----
    a_res_from_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(adv && frame_end))
        else $error("result raised without a frame-ending beat");

    a_clean_after_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && frame_end) |=> (r_col == '0 && r_line == '0 && !r_any && !r_hit))
        else $error("frame state not cleared after frame end");

    a_range_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.changed ? (o_res.first_dirty_line <= o_res.last_dirty_line)
                                      : (o_res.first_dirty_line == '0 &&
                                         o_res.last_dirty_line == '0)))
        else $error("dirty line range malformed");

endmodule

[dv/tb_sampled_frame_dirty_line_detector_core.sv]
`timescale 1ns / 1ps

module tb_sampled_frame_dirty_line_detector_core;

    localparam int CFG_W        = sfdl_pkg::CFG_W;
    localparam int CFG_IDX_W    = sfdl_pkg::CFG_IDX_W;
    localparam int PHASE_W      = sfdl_pkg::PHASE_W;
    localparam int LINE_FIELD_W = sfdl_pkg::LINE_FIELD_W;

    localparam int KEEP            = -1;    // table entry: leave register alone
    localparam int LATENCY_WAIT    = 4;     // wait for the result register, plus margin
    localparam int HOLD_CYCLES     = 200;   // long result hold-off
    localparam int PRESSURE_BEATS  = 40;
    localparam int RAND_PAIRS      = 600;
    localparam int RAND_FRAMES_MIN = 16;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DIM_LIMIT       = 4096;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;   // no register behind it

    typedef struct packed {
        logic                    changed;
        logic [LINE_FIELD_W-1:0] first_line;
        logic [LINE_FIELD_W-1:0] last_line;
        logic [LINE_FIELD_W-1:0] last_col;
    } t_frame_report;

    // How the pixel pairs of a frame are made up
    typedef enum int {
        PAT_CLEAN,      // new equals old everywhere
        PAT_ALL,        // every pixel inverted
        PAT_LAST,       // only the very last pixel differs, in bit 0
        PAT_BIT0,       // every pixel differs in bit 0 only
        PAT_BIT31,      // every pixel differs in bit 31 only
        PAT_SPARSE,     // random old, about one pixel in sixteen differs
        PAT_DENSE       // random old, about every other pixel differs
    } t_pix_pattern;

    typedef struct {
        int            width;
        int            height;
        int            phase;
        t_pix_pattern  pat;
        logic [31:0]   base;
        int            cut;     // 0: whole frame, else pixels before the frame is closed
        bit            has_exp;
        t_frame_report exp;
    } t_dir_frame;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    sfdl_pix_if pix_if ();
    sfdl_res_if res_if ();

    sampled_frame_dirty_line_detector_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pix      (pix_if.sink),
        .o_res      (res_if.source)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow of the block: register copies as written, raw 13/6-bit values
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]   width_reg  = CFG_W'(sfdl_pkg::RESET_WIDTH);
    logic [CFG_W-1:0]   height_reg = CFG_W'(sfdl_pkg::RESET_HEIGHT);
    logic [PHASE_W-1:0] shift_reg  = PHASE_W'(sfdl_pkg::RESET_PHASE);

    // Scan state, clean frame after reset
    int unsigned scan_col    = 0;
    int unsigned scan_line   = 0;
    int unsigned scan_phase  = 0;
    int unsigned line_phase  = 0;
    bit          line_done   = 1'b0;   // a difference already seen in this line
    bit          frame_dirty = 1'b0;
    int unsigned dirty_lo    = 0;
    int unsigned dirty_hi    = 0;

    t_frame_report frame_reports_q[$];

    int err_cnt       = 0;
    int pairs_sent    = 0;
    int frames_sent   = 0;
    int reports_seen  = 0;
    int changed_seen  = 0;
    int idle_pct      = 35;
    int hold_req_cnt  = 0;
    int hold_seen_cnt = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    t_dir_frame dir_tbl [23];

    // Sizes of 0 count as 1, anything past the largest frame as the largest
    function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > DIM_LIMIT) return DIM_LIMIT;
        return v;
    endfunction

    // Advances the shadow by one pixel pair; returns 1 with the frame report
    // when the pair closes a frame.
    function automatic bit scan_pixel_pair(input logic [31:0] old_px, input logic [31:0] new_px,
                                           output t_frame_report rpt);
        int unsigned w, h, slip, stride;
        w = eff_dim(width_reg);
        h = eff_dim(height_reg);
        // slip steps at 540, 720, 1080 and 1440 lines
        if (h < 540)       slip = 2;
        else if (h < 720)  slip = 3;
        else if (h < 1080) slip = 4;
        else if (h < 1440) slip = 5;
        else               slip = 6;
        stride = slip * slip - 1;
        rpt = '0;

        // New line: phase reloads at frame start, else moves on by slip
        if (scan_col == 0) begin
            if (scan_line == 0)
                line_phase = shift_reg % stride;
            else
                line_phase = (line_phase + slip) % stride;
            scan_phase = line_phase;
            line_done  = 1'b0;
        end

        if (!line_done) begin
            if (scan_phase == 0) begin
                if (old_px != new_px) begin
                    if (!frame_dirty)
                        dirty_lo = (scan_line >= slip) ? scan_line - slip : 0;
                    frame_dirty = 1'b1;
                    dirty_hi    = scan_line + slip;
                    line_done   = 1'b1;
                end
                scan_phase = stride - 1;
            end else begin
                scan_phase--;
            end
        end

        if (scan_col + 1 >= w) begin
            scan_col = 0;
            if (scan_line + 1 >= h) begin
                rpt.changed = frame_dirty;
                if (frame_dirty) begin
                    rpt.first_line = LINE_FIELD_W'((dirty_lo < h - 1) ? dirty_lo : h - 1);
                    rpt.last_line  = LINE_FIELD_W'((dirty_hi < h - 1) ? dirty_hi : h - 1);
                end
                rpt.last_col = LINE_FIELD_W'(w - 1);
                scan_line   = 0;
                frame_dirty = 1'b0;
                line_done   = 1'b0;
                dirty_lo    = 0;
                dirty_hi    = 0;
                return 1'b1;
            end
            scan_line++;
        end else begin
            scan_col++;
        end
        return 1'b0;
    endfunction

    function automatic logic [31:0] flip_mask();
        logic [31:0] m;
        m = $urandom_range(1) ? (32'h1 << $urandom_range(31)) : $urandom;
        return (m == 0) ? 32'h1 : m;
    endfunction

    // ------------------------------------------------------------------
    // Config port: one write per edge, enable dropped by the caller
    // ------------------------------------------------------------------
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            sfdl_pkg::CFG_FRAME_WIDTH:  width_reg  = val;
            sfdl_pkg::CFG_FRAME_HEIGHT: height_reg = val;
            sfdl_pkg::CFG_PHASE_SHIFT:  shift_reg  = val[PHASE_W-1:0];
            default: ;
        endcase
    endtask

    // Drops valid, waits for every report to come back, then lets the
    // pipeline drain before anything touches the registers.
    task automatic settle();
        pix_if.valid <= 1'b0;
        while (frame_reports_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY_WAIT) @(posedge i_clk);
    endtask

    // One pixel-pair beat; the expectation is queued on acceptance
    task automatic send_pair(input logic [31:0] old_px, input logic [31:0] new_px,
                             input bit use_typed, input t_frame_report typed);
        t_frame_report rpt;
        while ($urandom_range(99) < idle_pct) begin
            pix_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_if.valid     <= 1'b1;
        pix_if.old_pixel <= old_px;
        pix_if.new_pixel <= new_px;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        pairs_sent++;
        if (scan_pixel_pair(old_px, new_px, rpt))
            frame_reports_q.push_back(use_typed ? typed : rpt);
    endtask

    // A frame at the current register setting. With a cut, the sizes are
    // shrunk to the scan position after that many pixels, so the next pixel
    // closes the frame early.
    task automatic send_frame(input t_pix_pattern pat, input logic [31:0] base,
                              input int unsigned cut,
                              input bit has_exp, input t_frame_report exp);
        int unsigned total;
        bit          cut_short;
        logic [31:0] a, b;
        total = eff_dim(width_reg) * eff_dim(height_reg);
        cut_short = (cut != 0) && (cut < total);
        if (cut_short)
            total = cut + 1;
        for (int unsigned n = 0; n < total; n++) begin
            if (cut_short && n == cut) begin
                settle();
                put_reg(sfdl_pkg::CFG_FRAME_WIDTH, CFG_W'(scan_col + 1));
                put_reg(sfdl_pkg::CFG_FRAME_HEIGHT, CFG_W'(scan_line + 1));
                cfg_we <= 1'b0;
            end
            a = (pat == PAT_SPARSE || pat == PAT_DENSE) ? $urandom : base;
            b = a;
            case (pat)
                PAT_ALL:    b = ~a;
                PAT_LAST:   if (n == total - 1) b = a ^ 32'h1;
                PAT_BIT0:   b = a ^ 32'h1;
                PAT_BIT31:  b = a ^ 32'h8000_0000;
                PAT_SPARSE: if ($urandom_range(15) == 0) b = a ^ flip_mask();
                PAT_DENSE:  if ($urandom_range(1) == 0) b = a ^ flip_mask();
                default: ;
            endcase
            send_pair(a, b, has_exp && (n == total - 1), exp);
        end
        frames_sent++;
    endtask

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure, one long hold-off on request,
    // every accepted report checked against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_frame_report want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                reports_seen++;
                if (res_if.changed) changed_seen++;
                if (frame_reports_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected frame report, expected none, actual changed %0b lines %0d..%0d col %0d",
                             $time, res_if.changed, res_if.first_dirty_line,
                             res_if.last_dirty_line, res_if.last_column);
                end else begin
                    want = frame_reports_q.pop_front();
                    check_field("changed", want.changed, res_if.changed);
                    check_field("first_dirty_line", want.first_line, res_if.first_dirty_line);
                    check_field("last_dirty_line", want.last_line, res_if.last_dirty_line);
                    check_field("last_column", want.last_col, res_if.last_column);
                end
            end
            if (hold_req_cnt != hold_seen_cnt) begin
                hold_seen_cnt = hold_req_cnt;
                hold_left     = HOLD_CYCLES;
                res_if.ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    // Watchdog: too long without a beat on either channel
    always @(posedge i_clk) begin
        if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
            $display("tb_sampled_frame_dirty_line_detector_core NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int rand_start, rand_frames, w, h, cut;
        pix_if.valid     = 1'b0;
        pix_if.old_pixel = '0;
        pix_if.new_pixel = '0;
        cfg_we           = 1'b0;
        cfg_idx          = sfdl_pkg::CFG_FRAME_WIDTH;
        cfg_data         = '0;
        i_rst_n          = 1'b0;

        // Directed frames. Typed reports only where obvious; the rest go
        // through the shadow. The first row keeps the reset sizes and phase.
        dir_tbl = '{
            '{KEEP, KEEP, KEEP, PAT_DENSE,  32'h0,         60, 1'b0, '0},
            '{1,    1,    0,    PAT_CLEAN,  32'hFFFF_FFFF, 0,  1'b1, '{1'b0, 12'd0, 12'd0, 12'd0}},
            '{1,    1,    0,    PAT_BIT31,  32'h0,         0,  1'b1, '{1'b1, 12'd0, 12'd0, 12'd0}},
            // zero sizes act as one
            '{0,    0,    0,    PAT_BIT0,   32'hFFFF_FFFF, 0,  1'b1, '{1'b1, 12'd0, 12'd0, 12'd0}},
            // phase one: column zero never sampled
            '{1,    1,    1,    PAT_ALL,    32'h0,         0,  1'b1, '{1'b0, 12'd0, 12'd0, 12'd0}},
            // dirty on the last line only: range pulled back by slip, top clamped
            '{3,    8,    0,    PAT_LAST,   32'h0,         0,  1'b1, '{1'b1, 12'd5, 12'd7, 12'd2}},
            '{64,   1,    0,    PAT_LAST,   32'h0,         0,  1'b1, '{1'b1, 12'd0, 12'd0, 12'd63}},
            // oversize sizes clamp to the largest frame
            '{8191, 8191, 0,    PAT_DENSE,  32'h0,         40, 1'b0, '0},
            '{6,    4,    2,    PAT_DENSE,  32'h0,         0,  1'b0, '0},
            '{12,   8,    3,    PAT_SPARSE, 32'h0,         0,  1'b0, '0},
            // either side of every slip step, closed early a few dozen lines in
            '{1,    539,  0,    PAT_ALL,    32'h0,         48, 1'b0, '0},
            '{1,    540,  0,    PAT_ALL,    32'h0,         48, 1'b0, '0},
            '{1,    719,  5,    PAT_ALL,    32'h0,         48, 1'b0, '0},
            '{1,    720,  7,    PAT_ALL,    32'h0,         48, 1'b0, '0},
            '{2,    1079, 11,   PAT_DENSE,  32'h0,         64, 1'b0, '0},
            '{1,    1080, 34,   PAT_ALL,    32'h0,         48, 1'b0, '0},
            '{1,    1439, 20,   PAT_ALL,    32'h0,         48, 1'b0, '0},
            '{1,    1440, 34,   PAT_ALL,    32'h0,         60, 1'b0, '0},
            '{1,    1440, 35,   PAT_ALL,    32'h0,         60, 1'b0, '0},
            '{1,    1440, 63,   PAT_ALL,    32'h0,         60, 1'b0, '0},
            '{1,    4096, 0,    PAT_ALL,    32'h0,         48, 1'b0, '0},
            '{1,    8191, 63,   PAT_SPARSE, 32'h0,         48, 1'b0, '0},
            '{5,    5,    63,   PAT_DENSE,  32'h0,         0,  1'b0, '0}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tbl[r]) begin
            settle();
            if (dir_tbl[r].width != KEEP)
                put_reg(sfdl_pkg::CFG_FRAME_WIDTH, CFG_W'(dir_tbl[r].width));
            if (dir_tbl[r].height != KEEP)
                put_reg(sfdl_pkg::CFG_FRAME_HEIGHT, CFG_W'(dir_tbl[r].height));
            if (dir_tbl[r].phase != KEEP)
                put_reg(sfdl_pkg::CFG_PHASE_SHIFT, CFG_W'(dir_tbl[r].phase));
            cfg_we <= 1'b0;
            send_frame(dir_tbl[r].pat, dir_tbl[r].base, dir_tbl[r].cut,
                       dir_tbl[r].has_exp, dir_tbl[r].exp);
        end

        // Back-pressure: one-pixel frames, each beat a report, while the
        // result side holds off. The block must fill and stall its input.
        settle();
        put_reg(sfdl_pkg::CFG_FRAME_WIDTH, CFG_W'(1));
        put_reg(sfdl_pkg::CFG_FRAME_HEIGHT, CFG_W'(1));
        put_reg(sfdl_pkg::CFG_PHASE_SHIFT, CFG_W'(0));
        cfg_we <= 1'b0;
        hold_req_cnt++;
        repeat (PRESSURE_BEATS) send_frame(PAT_DENSE, 32'h0, 0, 1'b0, '0);

        // Random frames, mostly small; now and then a tall narrow one,
        // closed early, to reach the larger slips. A stretch of frames runs
        // with no idling.
        rand_start  = pairs_sent;
        rand_frames = 0;
        while (pairs_sent - rand_start < RAND_PAIRS || rand_frames < RAND_FRAMES_MIN) begin
            settle();
            idle_pct = (rand_frames >= 8 && rand_frames < 16) ? 0 : 35;
            cut = 0;
            if ($urandom_range(39) == 0) begin
                w   = 1;
                h   = $urandom_range(540, 1500);
                cut = $urandom_range(20, 60);
            end else begin
                w = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 12);
                h = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 12);
            end
            put_reg(sfdl_pkg::CFG_FRAME_WIDTH, CFG_W'(w));
            put_reg(sfdl_pkg::CFG_FRAME_HEIGHT, CFG_W'(h));
            // upper data bits are junk for the phase register
            if (rand_frames == 0 || $urandom_range(1) == 0)
                put_reg(sfdl_pkg::CFG_PHASE_SHIFT, CFG_W'($urandom));
            if ($urandom_range(7) == 0)
                put_reg(CFG_UNUSED_IDX, CFG_W'($urandom));
            cfg_we <= 1'b0;
            case ($urandom_range(9))
                0, 1:    send_frame(PAT_CLEAN, $urandom, cut, 1'b0, '0);
                2:       send_frame(($urandom_range(1) != 0) ? PAT_ALL : PAT_LAST,
                                    $urandom, cut, 1'b0, '0);
                3, 4, 5: send_frame(PAT_DENSE, 32'h0, cut, 1'b0, '0);
                default: send_frame(PAT_SPARSE, 32'h0, cut, 1'b0, '0);
            endcase
            rand_frames++;
        end

        settle();
        repeat (2 * LATENCY_WAIT) @(posedge i_clk);

        $display("covered %0d pixel pairs in %0d frames (%0d directed, %0d random)",
                 pairs_sent, frames_sent, $size(dir_tbl), rand_frames);
        $display("checked %0d frame reports, %0d of them dirty, %0d mismatches",
                 reports_seen, changed_seen, err_cnt);
        if (err_cnt == 0)
            $display("tb_sampled_frame_dirty_line_detector_core OK");
        else
            $display("tb_sampled_frame_dirty_line_detector_core NOT OK");
        $finish;
    end

endmodule
